[sv/rtcnv_pkg.sv]
package rtcnv_pkg;

  localparam int RAM_BYTES = 64;
  localparam int IDX_W = $clog2(RAM_BYTES);

  localparam logic [2:0] ACT_WR_INDEX = 3'd0;
  localparam logic [2:0] ACT_RD_INDEX = 3'd1;
  localparam logic [2:0] ACT_WR_DATA  = 3'd2;
  localparam logic [2:0] ACT_RD_DATA  = 3'd3;
  localparam logic [2:0] ACT_RESET    = 3'd4;

  localparam logic [IDX_W-1:0] IDX_SEC    = IDX_W'(0);
  localparam logic [IDX_W-1:0] IDX_SEC_AL = IDX_W'(1);
  localparam logic [IDX_W-1:0] IDX_MIN    = IDX_W'(2);
  localparam logic [IDX_W-1:0] IDX_MIN_AL = IDX_W'(3);
  localparam logic [IDX_W-1:0] IDX_HOUR   = IDX_W'(4);
  localparam logic [IDX_W-1:0] IDX_HR_AL  = IDX_W'(5);
  localparam logic [IDX_W-1:0] IDX_WDAY   = IDX_W'(6);
  localparam logic [IDX_W-1:0] IDX_DAY    = IDX_W'(7);
  localparam logic [IDX_W-1:0] IDX_MONTH  = IDX_W'(8);
  localparam logic [IDX_W-1:0] IDX_YEAR   = IDX_W'(9);
  localparam logic [IDX_W-1:0] IDX_A      = IDX_W'(10);
  localparam logic [IDX_W-1:0] IDX_B      = IDX_W'(11);
  localparam logic [IDX_W-1:0] IDX_C      = IDX_W'(12);
  localparam logic [IDX_W-1:0] IDX_D      = IDX_W'(13);

  localparam logic [7:0] B_24H    = 8'h02;
  localparam logic [7:0] B_DM     = 8'h04;
  localparam logic [7:0] B_SET    = 8'h80;
  localparam logic [7:0] A_UIP    = 8'h80;
  localparam logic [7:0] IRQ_MASK = 8'h70;
  localparam logic [7:0] C_IRQF   = 8'h80;
  localparam logic [7:0] C_RELOAD = 8'h50;
  localparam logic [7:0] B_RST_CLR = 8'h78;

  localparam logic [7:0] A_RESET      = 8'd42;
  localparam logic [7:0] B_RESET      = 8'h06;
  localparam logic [7:0] C_RESET      = 8'h00;
  localparam logic [7:0] YEAR_OFF_RESET = 8'd68;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] write_byte;
    logic [5:0] now_second;
    logic [5:0] now_minute;
    logic [4:0] now_hour;
    logic [2:0] now_weekday;
    logic [4:0] now_day;
    logic [3:0] now_month;
    logic [7:0] now_year;
  } in_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       is_read;
  } out_t;

  typedef struct packed {
    logic latch;
    logic bin;
    logic h24;
  } clk_ctl_t;

  function automatic logic [7:0] to_mode(input logic [7:0] v, input logic bin);
    logic [15:0] p;
    logic [4:0]  q;
    logic [7:0]  r;
    // divide by ten through a reciprocal, exact for 8-bit values
    p = 16'(v) * 16'd205;
    q = p[15:11];
    r = v - 8'(q) * 8'd10;
    return bin ? v : {q[3:0], r[3:0]};
  endfunction

  function automatic logic [7:0] reload_c(input logic [7:0] b);
    return ((b & C_RELOAD) != 8'h00) ? (C_RELOAD | C_IRQF) : C_RELOAD;
  endfunction

  function automatic logic [7:0] power_on(input logic [IDX_W-1:0] i);
    logic [7:0] v;
    unique case (i)
      IDX_W'(0):  v = 8'd48;
      IDX_W'(1):  v = 8'd255;
      IDX_W'(2):  v = 8'd21;
      IDX_W'(3):  v = 8'd255;
      IDX_W'(4):  v = 8'd23;
      IDX_W'(5):  v = 8'd255;
      IDX_W'(6):  v = 8'd1;
      IDX_W'(7):  v = 8'd25;
      IDX_W'(8):  v = 8'd3;
      IDX_W'(9):  v = 8'd33;
      IDX_W'(10): v = A_RESET;
      IDX_W'(11): v = B_RESET;
      IDX_W'(13): v = 8'h80;
      IDX_W'(22): v = 8'd17;
      IDX_W'(23): v = 8'd46;
      IDX_W'(24): v = 8'd32;
      IDX_W'(25): v = 8'd1;
      IDX_W'(26): v = 8'd255;
      IDX_W'(28): v = 8'd1;
      IDX_W'(29): v = 8'd10;
      IDX_W'(30): v = 8'd135;
      default:    v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

[sv/rtcnv_ram.sv]
module rtcnv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/rtcnv_clock.sv]
module rtcnv_clock (
  input  logic                     clk,
  input  logic                     rst,
  input  rtcnv_pkg::clk_ctl_t      ctl,
  input  rtcnv_pkg::in_t           now,
  input  logic [7:0]               year_off,
  input  logic [rtcnv_pkg::IDX_W-1:0] idx,
  output logic [7:0]               clk_byte
);

  logic [5:0] held_second;
  logic [5:0] held_minute;
  logic [4:0] held_hour;
  logic [2:0] held_weekday;
  logic [4:0] held_day;
  logic [3:0] held_month;
  logic [7:0] held_year;

  logic [5:0] sec;
  logic [5:0] mins;
  logic [4:0] hr;
  logic [2:0] wday;
  logic [4:0] day;
  logic [3:0] mon;
  logic [7:0] yr;
  logic [4:0] h12;
  logic [7:0] pm;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_second  <= '0;
      held_minute  <= '0;
      held_hour    <= '0;
      held_weekday <= '0;
      held_day     <= '0;
      held_month   <= '0;
      held_year    <= '0;
    end else if (ctl.latch) begin
      held_second  <= now.now_second;
      held_minute  <= now.now_minute;
      held_hour    <= now.now_hour;
      held_weekday <= now.now_weekday;
      held_day     <= now.now_day;
      held_month   <= now.now_month;
      held_year    <= now.now_year;
    end
  end

  // a latching read returns the time it latches
  assign sec  = ctl.latch ? now.now_second  : held_second;
  assign mins = ctl.latch ? now.now_minute  : held_minute;
  assign hr   = ctl.latch ? now.now_hour    : held_hour;
  assign wday = ctl.latch ? now.now_weekday : held_weekday;
  assign day  = ctl.latch ? now.now_day     : held_day;
  assign mon  = ctl.latch ? now.now_month   : held_month;
  assign yr   = ctl.latch ? now.now_year    : held_year;

  always_comb begin
    pm = (hr >= 5'd12) ? 8'h80 : 8'h00;
    priority if (hr < 5'd12) begin
      h12 = hr;
    end else if (hr < 5'd24) begin
      h12 = hr - 5'd12;
    end else begin
      h12 = hr - 5'd24;
    end
    if (h12 == 5'd0) begin
      h12 = 5'd12;
    end
  end

  always_comb begin
    unique case (idx)
      rtcnv_pkg::IDX_SEC:   clk_byte = rtcnv_pkg::to_mode(8'(sec), ctl.bin);
      rtcnv_pkg::IDX_MIN:   clk_byte = rtcnv_pkg::to_mode(8'(mins), ctl.bin);
      rtcnv_pkg::IDX_HOUR: begin
        if (ctl.h24) begin
          clk_byte = rtcnv_pkg::to_mode(8'(hr), ctl.bin);
        end else begin
          clk_byte = rtcnv_pkg::to_mode(8'(h12), ctl.bin) | pm;
        end
      end
      rtcnv_pkg::IDX_WDAY:  clk_byte = rtcnv_pkg::to_mode(8'(wday) + 8'd1, ctl.bin);
      rtcnv_pkg::IDX_DAY:   clk_byte = rtcnv_pkg::to_mode(8'(day), ctl.bin);
      rtcnv_pkg::IDX_MONTH: clk_byte = rtcnv_pkg::to_mode(8'(mon) + 8'd1, ctl.bin);
      rtcnv_pkg::IDX_YEAR:  clk_byte = rtcnv_pkg::to_mode(yr - year_off, ctl.bin);
      default:              clk_byte = 8'h00;
    endcase
  end

endmodule

[sv/rtc_nvram_register_file.sv]
// channel   signals                          beat when
// item      item_valid, item_ready, item     item_valid & item_ready
// result    result_valid, result_ready, res  result_valid & result_ready
// config    cfg_we, cfg_wdata                cfg_we
//
// an item is registered on acceptance while the byte file ram is read; the
// processing state then modifies, writes back and loads the result register.
// a new item is taken while a result waits. rst returns the control registers
// to reset values and clears the per-byte valid flags; bytes not yet written
// read from the power-on table. a result stalled at the output holds ST_PROC.
module rtc_nvram_register_file (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  rtcnv_pkg::in_t    item,
  output logic              result_valid,
  input  logic              result_ready,
  output rtcnv_pkg::out_t   result,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PROC = 1'b1;

  logic                          state;
  rtcnv_pkg::in_t                item_q;
  logic [rtcnv_pkg::IDX_W-1:0]   sel_index;
  logic [rtcnv_pkg::IDX_W-1:0]   sel_index_next;
  logic [7:0]                    reg_a;
  logic [7:0]                    reg_a_next;
  logic [7:0]                    reg_b;
  logic [7:0]                    reg_b_next;
  logic [7:0]                    reg_c;
  logic [7:0]                    reg_c_next;
  logic [7:0]                    year_off;
  logic [rtcnv_pkg::RAM_BYTES-1:0] vld;
  rtcnv_pkg::out_t               result_next;

  logic                          accept;
  logic                          fire;
  logic                          ram_we;
  logic [7:0]                    ram_q;
  logic [7:0]                    rdata;
  logic [7:0]                    clk_byte;
  logic                          latch;
  logic                          is_clock;
  rtcnv_pkg::clk_ctl_t           clk_ctl;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign fire       = (state == ST_PROC) && (!result_valid || result_ready);

  rtcnv_ram #(
    .WIDTH(8),
    .DEPTH(rtcnv_pkg::RAM_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(sel_index),
    .wdata(item_q.write_byte),
    .raddr(sel_index),
    .rdata(ram_q)
  );

  // unwritten bytes come from the power-on table
  assign rdata = vld[sel_index] ? ram_q : rtcnv_pkg::power_on(sel_index);

  assign clk_ctl.latch = latch && fire;
  assign clk_ctl.bin   = (reg_b & rtcnv_pkg::B_DM) != 8'h00;
  assign clk_ctl.h24   = (reg_b & rtcnv_pkg::B_24H) != 8'h00;

  rtcnv_clock u_clock (
    .clk     (clk),
    .rst     (rst),
    .ctl     (clk_ctl),
    .now     (item_q),
    .year_off(year_off),
    .idx     (sel_index),
    .clk_byte(clk_byte)
  );

  assign is_clock = (sel_index == rtcnv_pkg::IDX_SEC)  || (sel_index == rtcnv_pkg::IDX_MIN)
                 || (sel_index == rtcnv_pkg::IDX_HOUR) || (sel_index == rtcnv_pkg::IDX_WDAY)
                 || (sel_index == rtcnv_pkg::IDX_DAY)  || (sel_index == rtcnv_pkg::IDX_MONTH)
                 || (sel_index == rtcnv_pkg::IDX_YEAR);

  always_comb begin
    sel_index_next = sel_index;
    reg_a_next     = reg_a;
    reg_b_next     = reg_b;
    reg_c_next     = reg_c;
    result_next    = '0;
    ram_we         = 1'b0;
    latch          = 1'b0;
    unique case (item_q.action)
      rtcnv_pkg::ACT_WR_INDEX: begin
        if (item_q.write_byte < 8'(rtcnv_pkg::RAM_BYTES)) begin
          sel_index_next = item_q.write_byte[rtcnv_pkg::IDX_W-1:0];
        end
      end
      rtcnv_pkg::ACT_RD_INDEX: begin
        result_next.read_byte = 8'(sel_index);
        result_next.is_read   = 1'b1;
      end
      rtcnv_pkg::ACT_WR_DATA: begin
        priority if (sel_index == rtcnv_pkg::IDX_C || sel_index == rtcnv_pkg::IDX_D) begin
          // read-only status bytes
        end else if (sel_index == rtcnv_pkg::IDX_A) begin
          reg_a_next = (item_q.write_byte & ~rtcnv_pkg::A_UIP) | (reg_a & rtcnv_pkg::A_UIP);
        end else if (sel_index == rtcnv_pkg::IDX_B) begin
          if (((item_q.write_byte & rtcnv_pkg::IRQ_MASK) != 8'h00)
              && ((reg_c & rtcnv_pkg::IRQ_MASK) != 8'h00)) begin
            reg_c_next = reg_c | rtcnv_pkg::C_IRQF;
          end
          latch      = (item_q.write_byte & rtcnv_pkg::B_SET) != 8'h00;
          reg_b_next = item_q.write_byte;
        end else begin
          ram_we = 1'b1;
        end
      end
      rtcnv_pkg::ACT_RD_DATA: begin
        result_next.is_read = 1'b1;
        priority if (is_clock) begin
          latch                 = (reg_b & rtcnv_pkg::B_SET) == 8'h00;
          result_next.read_byte = clk_byte;
        end else if (sel_index == rtcnv_pkg::IDX_SEC_AL || sel_index == rtcnv_pkg::IDX_MIN_AL
                     || sel_index == rtcnv_pkg::IDX_HR_AL) begin
          result_next.read_byte = rtcnv_pkg::to_mode(rdata, clk_ctl.bin);
        end else if (sel_index == rtcnv_pkg::IDX_A) begin
          if ((reg_b & rtcnv_pkg::B_SET) != 8'h00) begin
            reg_a_next = reg_a & ~rtcnv_pkg::A_UIP;
          end else begin
            reg_a_next = reg_a ^ rtcnv_pkg::A_UIP;
          end
          result_next.read_byte = reg_a_next;
        end else if (sel_index == rtcnv_pkg::IDX_B) begin
          result_next.read_byte = reg_b;
        end else if (sel_index == rtcnv_pkg::IDX_C) begin
          result_next.read_byte = reg_c;
          reg_c_next            = rtcnv_pkg::reload_c(reg_b);
        end else begin
          result_next.read_byte = rdata;
        end
      end
      rtcnv_pkg::ACT_RESET: begin
        reg_b_next     = reg_b & ~rtcnv_pkg::B_RST_CLR;
        reg_c_next     = rtcnv_pkg::reload_c(reg_b_next);
        sel_index_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
      sel_index    <= '0;
      reg_a        <= rtcnv_pkg::A_RESET;
      reg_b        <= rtcnv_pkg::B_RESET;
      reg_c        <= rtcnv_pkg::C_RESET;
      year_off     <= rtcnv_pkg::YEAR_OFF_RESET;
      vld          <= '0;
    end else begin
      if (cfg_we) begin
        year_off <= cfg_wdata;
      end
      if (accept) begin
        state <= ST_PROC;
      end
      if (fire) begin
        state        <= ST_IDLE;
        result_valid <= 1'b1;
        sel_index    <= sel_index_next;
        reg_a        <= reg_a_next;
        reg_b        <= reg_b_next;
        reg_c        <= reg_c_next;
        if (ram_we) begin
          vld[sel_index] <= 1'b1;
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
    if (fire) begin
      result <= result_next;
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import rtcnv_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam logic [7:0] POWER_ON_BYTES [0:30] = '{
    8'd48, 8'd255, 8'd21, 8'd255, 8'd23, 8'd255, 8'd1, 8'd25, 8'd3, 8'd33,
    8'd42, 8'h06, 8'h00, 8'h80, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
    8'd0, 8'd17, 8'd46, 8'd32, 8'd1, 8'd255, 8'd0, 8'd1, 8'd10, 8'd135
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  in_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  out_t result;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  always #4 clk = ~clk;

  rtc_nvram_register_file dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // predicted chip state
  logic [7:0] nv_ram [RAM_BYTES];
  logic [IDX_W-1:0] cur_index;
  logic [5:0] held_sec, held_min;
  logic [4:0] held_hr, held_day;
  logic [2:0] held_wday;
  logic [3:0] held_mon;
  logic [7:0] held_yr;
  logic [7:0] year_off;

  out_t expected_bus_data [$];
  int errors = 0;
  int items_sent = 0;
  bit sender_fast = 1'b0;
  bit reader_fast = 1'b0;
  int quiet_cycles = 0;

  function automatic void chip_power_on();
    for (int i = 0; i < RAM_BYTES; i++) begin
      nv_ram[i] = (i <= 30) ? POWER_ON_BYTES[i] : 8'h00;
    end
    cur_index = '0;
    {held_sec, held_min, held_hr, held_wday, held_day, held_mon, held_yr} = '0;
    year_off = YEAR_OFF_RESET;
  endfunction

  function automatic logic [7:0] as_mode(int unsigned v);
    int unsigned b;
    b = v & 32'hff;
    if ((nv_ram[IDX_B] & B_DM) != 0) return 8'(b);
    // bcd, tens digit may spill past 9 and is cut to 8 bits
    return 8'(((b / 10) << 4) | (b % 10));
  endfunction

  function automatic logic [7:0] c_after_read();
    return ((nv_ram[IDX_B] & 8'h50) != 0) ? 8'hd0 : 8'h50;
  endfunction

  function automatic void latch_now(in_t it);
    held_sec = it.now_second;
    held_min = it.now_minute;
    held_hr = it.now_hour;
    held_wday = it.now_weekday;
    held_day = it.now_day;
    held_mon = it.now_month;
    held_yr = it.now_year;
  endfunction

  function automatic void hold_time(in_t it);
    if ((nv_ram[IDX_B] & B_SET) == 0) latch_now(it);
  endfunction

  function automatic logic [7:0] fetch_byte(in_t it);
    int unsigned h;
    logic [7:0] pm;
    logic [7:0] v;
    case (cur_index)
      IDX_SEC_AL, IDX_MIN_AL, IDX_HR_AL: return as_mode(nv_ram[cur_index]);
      IDX_SEC: begin
        hold_time(it);
        return as_mode(held_sec);
      end
      IDX_MIN: begin
        hold_time(it);
        return as_mode(held_min);
      end
      IDX_HOUR: begin
        hold_time(it);
        h = held_hr;
        if ((nv_ram[IDX_B] & B_24H) != 0) return as_mode(h);
        pm = (h >= 12) ? 8'h80 : 8'h00;
        h = h % 12;
        if (h == 0) h = 12;
        return as_mode(h) | pm;
      end
      IDX_WDAY: begin
        hold_time(it);
        return as_mode(held_wday + 1);
      end
      IDX_DAY: begin
        hold_time(it);
        return as_mode(held_day);
      end
      IDX_MONTH: begin
        hold_time(it);
        return as_mode(held_mon + 1);
      end
      IDX_YEAR: begin
        hold_time(it);
        return as_mode(8'(held_yr - year_off));
      end
      IDX_A: begin
        if ((nv_ram[IDX_B] & B_SET) != 0) nv_ram[IDX_A] = nv_ram[IDX_A] & ~A_UIP;
        else nv_ram[IDX_A] = nv_ram[IDX_A] ^ A_UIP;
        return nv_ram[IDX_A];
      end
      IDX_C: begin
        v = nv_ram[IDX_C];
        nv_ram[IDX_C] = c_after_read();
        return v;
      end
      default: return nv_ram[cur_index];
    endcase
  endfunction

  function automatic void store_byte(in_t it);
    logic [7:0] v;
    v = it.write_byte;
    if (cur_index == IDX_C || cur_index == IDX_D) return;
    if (cur_index == IDX_A) v = (v & ~A_UIP) | (nv_ram[IDX_A] & A_UIP);
    if (cur_index == IDX_B) begin
      if ((v & IRQ_MASK) != 0 && (nv_ram[IDX_C] & IRQ_MASK) != 0)
        nv_ram[IDX_C] = nv_ram[IDX_C] | C_IRQF;
      if ((v & B_SET) != 0) latch_now(it);
    end
    nv_ram[cur_index] = v;
  endfunction

  function automatic out_t bus_response(in_t it);
    out_t r;
    r = '0;
    case (it.action)
      ACT_WR_INDEX: if (it.write_byte < RAM_BYTES) cur_index = it.write_byte[IDX_W-1:0];
      ACT_RD_INDEX: begin
        r.read_byte = 8'(cur_index);
        r.is_read = 1'b1;
      end
      ACT_WR_DATA: store_byte(it);
      ACT_RD_DATA: begin
        r.read_byte = fetch_byte(it);
        r.is_read = 1'b1;
      end
      ACT_RESET: begin
        nv_ram[IDX_B] = nv_ram[IDX_B] & ~B_RST_CLR;
        nv_ram[IDX_C] = c_after_read();
        cur_index = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // random host time, now and then with every field at full width
  function automatic in_t rand_item(logic [2:0] act, logic [7:0] wb);
    in_t it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it = raw[47:0];
    if ($urandom_range(0, 7) != 0) begin
      it.now_second = 6'($urandom_range(0, 60));
      it.now_minute = 6'($urandom_range(0, 59));
      it.now_hour = 5'($urandom_range(0, 23));
      it.now_weekday = 3'($urandom_range(0, 6));
      it.now_day = 5'($urandom_range(1, 31));
      it.now_month = 4'($urandom_range(0, 11));
    end
    it.action = act;
    it.write_byte = wb;
    return it;
  endfunction

  function automatic in_t at_time(logic [2:0] act, logic [7:0] wb, logic [5:0] s,
                                  logic [5:0] m, logic [4:0] h, logic [2:0] wd,
                                  logic [4:0] d, logic [3:0] mo, logic [7:0] y);
    in_t it;
    it = '{action: act, write_byte: wb, now_second: s, now_minute: m, now_hour: h,
           now_weekday: wd, now_day: d, now_month: mo, now_year: y};
    return it;
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send(in_t it);
    int gap;
    if ($urandom_range(0, 63) == 0) sender_fast = !sender_fast;
    gap = sender_fast ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    expected_bus_data.push_back(bus_response(it));
    items_sent++;
  endtask

  task automatic op(logic [2:0] act, logic [7:0] wb);
    send(rand_item(act, wb));
  endtask

  task automatic wait_results();
    item_valid <= 1'b0;
    while (expected_bus_data.size() != 0) @(posedge clk);
  endtask

  task automatic set_year_base(logic [7:0] v);
    wait_results();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    year_off = v;
  endtask

  task automatic test_power_on_table();
    op(ACT_RD_INDEX, 8'h00);
    op(ACT_WR_INDEX, 8'(IDX_D));
    op(ACT_RD_DATA, 8'h00);
    op(ACT_WR_INDEX, 8'd30);
    op(ACT_RD_DATA, 8'h00);
    op(ACT_WR_INDEX, 8'(IDX_SEC_AL));
    op(ACT_RD_DATA, 8'h00);
  endtask

  task automatic test_clock_fields();
    // bcd and 12-hour form first
    op(ACT_WR_INDEX, 8'(IDX_B));
    op(ACT_WR_DATA, 8'h00);
    op(ACT_WR_INDEX, 8'(IDX_HOUR));
    send(at_time(ACT_RD_DATA, 8'h00, 6'd60, 6'd59, 5'd0, 3'd6, 5'd31, 4'd11, 8'd0));
    send(at_time(ACT_RD_DATA, 8'h00, 6'd0, 6'd0, 5'd12, 3'd0, 5'd1, 4'd0, 8'd255));
    send(at_time(ACT_RD_DATA, 8'h00, 6'd0, 6'd0, 5'd23, 3'd0, 5'd1, 4'd0, 8'd255));
    send(at_time(ACT_RD_DATA, 8'h00, 6'd63, 6'd63, 5'd31, 3'd7, 5'd31, 4'd15, 8'd255));
    op(ACT_WR_INDEX, 8'(IDX_YEAR));
    send(at_time(ACT_RD_DATA, 8'h00, 6'd60, 6'd59, 5'd0, 3'd6, 5'd31, 4'd11, 8'd0));
    op(ACT_WR_INDEX, 8'(IDX_SEC));
    send(at_time(ACT_RD_DATA, 8'h00, 6'd60, 6'd59, 5'd0, 3'd6, 5'd31, 4'd11, 8'd0));
    // freeze the clock with set, binary, 24-hour
    op(ACT_WR_INDEX, 8'(IDX_B));
    send(at_time(ACT_WR_DATA, B_SET | B_DM | B_24H, 6'd33, 6'd44, 5'd22, 3'd3, 5'd9,
                 4'd8, 8'd123));
    op(ACT_WR_INDEX, 8'(IDX_MONTH));
    op(ACT_RD_DATA, 8'h00);
  endtask

  task automatic test_control_registers();
    op(ACT_WR_INDEX, 8'(IDX_A));
    op(ACT_RD_DATA, 8'h00);
    op(ACT_WR_DATA, 8'hff);
    op(ACT_WR_INDEX, 8'(IDX_B));
    op(ACT_WR_DATA, 8'h70);
    op(ACT_WR_INDEX, 8'(IDX_A));
    op(ACT_RD_DATA, 8'h00);
    op(ACT_RD_DATA, 8'h00);
    op(ACT_WR_INDEX, 8'(IDX_C));
    op(ACT_RD_DATA, 8'h00);
    op(ACT_WR_DATA, 8'hff);
    op(ACT_RD_DATA, 8'h00);
    op(ACT_WR_INDEX, 8'(IDX_B));
    op(ACT_WR_DATA, 8'h10);
    op(ACT_WR_INDEX, 8'(IDX_D));
    op(ACT_WR_DATA, 8'h00);
    op(ACT_RD_DATA, 8'h00);
  endtask

  task automatic test_index_and_reset();
    op(ACT_WR_INDEX, 8'(RAM_BYTES));
    op(ACT_WR_INDEX, 8'hff);
    op(ACT_RD_INDEX, 8'h00);
    for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++) op(3'(a), 8'hff);
    op(ACT_RESET, 8'hff);
    op(ACT_RD_INDEX, 8'h00);
    op(ACT_WR_INDEX, 8'(IDX_C));
    op(ACT_RD_DATA, 8'h00);
  endtask

  // mostly select-then-access sequences, the rest loose actions and noise
  task automatic bus_traffic(int count);
    int target;
    int pick;
    logic [7:0] idx;
    target = items_sent + count;
    while (items_sent < target) begin
      pick = $urandom_range(0, 15);
      if (pick < 10) begin
        idx = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 13))
                                          : 8'($urandom_range(0, RAM_BYTES - 1));
        op(ACT_WR_INDEX, idx);
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 2) == 0) op(ACT_WR_DATA, rand_byte());
          else op(ACT_RD_DATA, rand_byte());
        end
      end else if (pick < 12) begin
        op(ACT_RD_INDEX, rand_byte());
      end else if (pick == 12) begin
        if ($urandom_range(0, 2) == 0) op(ACT_RESET, rand_byte());
        else op(ACT_WR_INDEX, rand_byte());
      end else if (pick == 13) begin
        op(3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI)), rand_byte());
      end else begin
        op(3'($urandom), rand_byte());
      end
    end
  endtask

  task automatic test_random_traffic();
    bus_traffic(120);
    // hold off until every result has come back
    wait_results();
    bus_traffic(130);
    set_year_base(8'h00);
    bus_traffic(250);
    set_year_base(8'hff);
    bus_traffic(250);
    set_year_base(8'($urandom));
    bus_traffic(200);
  endtask

  // result side, ready stalls drawn per beat
  initial begin
    int stall;
    wait (!rst);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 47) == 0) reader_fast = !reader_fast;
      stall = reader_fast ? 0 : $urandom_range(0, 13);
      if (stall != 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  always @(posedge clk) begin
    out_t want;
    if (!rst && result_valid && result_ready) begin
      if (expected_bus_data.size() == 0) begin
        $error("result beat with nothing expected: read_byte %0h is_read %0b",
               result.read_byte, result.is_read);
        errors++;
      end else begin
        want = expected_bus_data.pop_front();
        if (result.read_byte !== want.read_byte) begin
          $error("read_byte: expected %0h, got %0h", want.read_byte, result.read_byte);
          errors++;
        end
        if (result.is_read !== want.is_read) begin
          $error("is_read: expected %0b, got %0b", want.is_read, result.is_read);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    chip_power_on();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_power_on_table();
    test_clock_fields();
    test_control_registers();
    test_index_and_reset();
    set_year_base(YEAR_OFF_RESET);
    test_random_traffic();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_bus_data.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

[rtc_nvram_register_file.f]
sv/rtcnv_pkg.sv
sv/rtcnv_ram.sv
sv/rtcnv_clock.sv
sv/rtc_nvram_register_file.sv
tb/tb_top.sv
